>>> rtl/obuss_pkg.sv
// Shared types and constants of the OBU size-field stripper.
// Used by the front parser, the command queue and the back formatter.
package obuss_pkg;

	// Parser phases of the front end.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EXT,
		PH_SIZE,
		PH_BODY,
		PH_DISCARD
	} obuss_phase_t;

	// Kinds of command passed from the front to the back.
	typedef enum logic [2:0] {
		CMD_HDR,
		CMD_FORB,
		CMD_EXT,
		CMD_BODY,
		CMD_MARK
	} obuss_kind_t;

	// One command: a classified byte or an end marker.
	typedef struct packed {
		obuss_kind_t kind;
		logic [7:0]  data;
		logic        last;
		logic        trunc;
	} obuss_cmd_t;

	// Header byte with the has-size bit cleared.
	localparam logic [7:0] HDR_SIZE_CLR_MASK = 8'hFD;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

endpackage

>>> rtl/av1_obu_size_field_stripper.sv
// AV1 OBU size-field stripper, top level. Uses obuss_pkg, obuss_front,
// obuss_fifo and obuss_back.
// Throughput: one byte per cycle; the front parser takes a byte every cycle
// unless the two-entry command queue is full.
// A result passes from the front through the command queue into the output
// register, where dst_stall can hold it. Discarded bytes make no result;
// size-field bytes make only an end marker, at buffer end or size zero.
// Reset (arst_n low, asynchronous): parser returns to the header phase, queue
// and output register empty.
module av1_obu_size_field_stripper import obuss_pkg::*; #(
	parameter int MAX_SIZE_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_last,
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        is_header_byte,
	output logic        obu_end,
	output logic [3:0]  obu_type,
	output logic [2:0]  temporal_id,
	output logic [1:0]  spatial_id,
	output logic        forbidden_error,
	output logic        size_truncated,
	output logic [31:0] body_length
);

	logic       take;
	logic       push;
	logic       pop;
	logic       q_not_empty;
	logic       q_full;
	obuss_cmd_t front_cmd;
	obuss_cmd_t back_cmd;

	// Input transfer when the queue has room.
	assign src_stall = q_full;
	assign take      = src_valid && !src_stall;

	obuss_front #(
		.MAX_SIZE_BYTES(MAX_SIZE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.buffer_last(buffer_last),
		.push       (push),
		.cmd        (front_cmd)
	);

	obuss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (front_cmd),
		.pop      (pop),
		.rd_cmd   (back_cmd),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	obuss_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_not_empty),
		.cmd            (back_cmd),
		.pop            (pop),
		.dst_valid      (dst_valid),
		.dst_stall      (dst_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.is_header_byte (is_header_byte),
		.obu_end        (obu_end),
		.obu_type       (obu_type),
		.temporal_id    (temporal_id),
		.spatial_id     (spatial_id),
		.forbidden_error(forbidden_error),
		.size_truncated (size_truncated),
		.body_length    (body_length)
	);

endmodule

>>> rtl/obuss_front.sv
// Front end of the OBU size-field stripper: parses the byte stream and
// decodes the LEB128 size field. Depends on obuss_pkg.
module obuss_front import obuss_pkg::*; #(
	parameter int MAX_SIZE_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       buffer_last,
	output logic       push,
	output obuss_cmd_t cmd
);

	localparam logic [3:0] MaxCnt = 4'(MAX_SIZE_BYTES);

	obuss_phase_t phase_q, phase_d;
	logic         has_size_q, has_size_d;
	logic         sized_q, sized_d;
	logic [31:0]  size_q, size_d;
	logic [3:0]   cnt_q, cnt_d;
	logic [31:0]  rem_q, rem_d;

	logic [5:0]   shamt;
	logic [63:0]  term;
	logic [32:0]  sum;
	logic [31:0]  size_new;
	logic [3:0]   cnt_inc;
	logic         size_done;
	logic [31:0]  rem_dec;
	logic         body_end;

	// LEB128 accumulate with saturation, and the body countdown.
	always_comb begin
		shamt     = {cnt_q[2:0], 3'b000} - {3'b000, cnt_q[2:0]};
		term      = 64'(data_byte[6:0]) << shamt;
		sum       = {1'b0, size_q} + {1'b0, term[31:0]};
		size_new  = ((|term[63:32]) || sum[32]) ? SAT32 : sum[31:0];
		cnt_inc   = cnt_q + 4'd1;
		size_done = !data_byte[7] || (cnt_inc >= MaxCnt);
		rem_dec   = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
		body_end  = sized_q ? ((rem_dec == 32'd0) || buffer_last) : buffer_last;
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					if (data_byte[7]) begin
						phase_d = buffer_last ? PH_HEADER : PH_DISCARD;
					end else if (buffer_last) begin
						phase_d = PH_HEADER;
					end else if (data_byte[2]) begin
						phase_d = PH_EXT;
					end else if (data_byte[1]) begin
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_BODY;
					end
				end
				PH_EXT: begin
					if (buffer_last) begin
						phase_d = PH_HEADER;
					end else if (has_size_q) begin
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_BODY;
					end
				end
				PH_SIZE: begin
					if (buffer_last || (size_done && size_new == 32'd0)) begin
						phase_d = PH_HEADER;
					end else if (size_done) begin
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					if (body_end) begin
						phase_d = PH_HEADER;
					end
				end
				PH_DISCARD: begin
					if (buffer_last) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end
	end

	// Commands and datapath updates.
	always_comb begin
		push       = 1'b0;
		cmd.kind   = CMD_MARK;
		cmd.data   = data_byte;
		cmd.last   = buffer_last;
		cmd.trunc  = 1'b0;
		has_size_d = has_size_q;
		sized_d    = sized_q;
		size_d     = size_q;
		cnt_d      = cnt_q;
		rem_d      = rem_q;
		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					has_size_d = data_byte[1];
					sized_d    = 1'b0;
					size_d     = 32'd0;
					cnt_d      = 4'd0;
					rem_d      = 32'd0;
					push       = 1'b1;
					if (data_byte[7]) begin
						cmd.kind = CMD_FORB;
						cmd.last = 1'b1;
					end else begin
						cmd.kind = CMD_HDR;
						cmd.data = data_byte & HDR_SIZE_CLR_MASK;
					end
				end
				PH_EXT: begin
					push     = 1'b1;
					cmd.kind = CMD_EXT;
				end
				PH_SIZE: begin
					size_d   = size_new;
					cnt_d    = cnt_inc;
					cmd.kind = CMD_MARK;
					cmd.last = 1'b1;
					if (!size_done) begin
						push      = buffer_last;
						cmd.trunc = 1'b1;
					end else begin
						rem_d     = size_new;
						sized_d   = 1'b1;
						push      = buffer_last || (size_new == 32'd0);
						cmd.trunc = (size_new != 32'd0);
					end
				end
				PH_BODY: begin
					push     = 1'b1;
					cmd.kind = CMD_BODY;
					cmd.last = body_end;
					if (sized_q) begin
						rem_d     = rem_dec;
						cmd.trunc = buffer_last && (rem_dec != 32'd0);
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			has_size_q <= 1'b0;
			sized_q    <= 1'b0;
			size_q     <= 32'd0;
			cnt_q      <= 4'd0;
			rem_q      <= 32'd0;
		end else begin
			phase_q    <= phase_d;
			has_size_q <= has_size_d;
			sized_q    <= sized_d;
			size_q     <= size_d;
			cnt_q      <= cnt_d;
			rem_q      <= rem_d;
		end
	end

	// A clean header that does not end the buffer never leads to discard.
	a_no_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_HEADER && !data_byte[7]) |=> phase_q != PH_DISCARD)
		else $error("clean header led to discard phase");

	// A forbidden header in mid-buffer always starts a discard.
	a_forb_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_HEADER && data_byte[7] && !buffer_last)
		|=> phase_q == PH_DISCARD)
		else $error("forbidden header did not start discard");

	// The size field never runs past its byte limit.
	a_size_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SIZE |-> cnt_q < MaxCnt)
		else $error("size field byte count beyond limit");

endmodule

>>> rtl/obuss_fifo.sv
// Two-entry command queue between the parser front and the output back.
// Depends on obuss_pkg for the command type.
module obuss_fifo import obuss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  obuss_cmd_t wr_cmd,
	input  logic       pop,
	output obuss_cmd_t rd_cmd,
	output logic       not_empty,
	output logic       full
);

	obuss_cmd_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign rd_cmd    = entry_q[rd_ptr_q];
	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");

endmodule

>>> rtl/obuss_back.sv
// Back end of the OBU size-field stripper: keeps per-OBU fields and the body
// count, and drives the output register. Depends on obuss_pkg.
module obuss_back import obuss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  obuss_cmd_t  cmd,
	output logic        pop,
	output logic        dst_valid,
	input  logic        dst_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        is_header_byte,
	output logic        obu_end,
	output logic [3:0]  obu_type,
	output logic [2:0]  temporal_id,
	output logic [1:0]  spatial_id,
	output logic        forbidden_error,
	output logic        size_truncated,
	output logic [31:0] body_length
);

	logic [3:0]  type_q, type_d;
	logic [2:0]  tid_q, tid_d;
	logic [1:0]  sid_q, sid_d;
	logic [31:0] cnt_q, cnt_d;
	logic        valid_q;

	logic [7:0]  byte_d;
	logic        bv_d, hdr_d, forb_d, trunc_d;

	assign pop = cmd_valid && (!valid_q || !dst_stall);

	// Per-OBU field updates and result formatting.
	always_comb begin
		type_d  = type_q;
		tid_d   = tid_q;
		sid_d   = sid_q;
		cnt_d   = cnt_q;
		byte_d  = 8'd0;
		bv_d    = 1'b0;
		hdr_d   = 1'b0;
		forb_d  = 1'b0;
		trunc_d = 1'b0;
		case (cmd.kind)
			CMD_HDR: begin
				type_d = cmd.data[6:3];
				tid_d  = 3'd0;
				sid_d  = 2'd0;
				cnt_d  = 32'd0;
				byte_d = cmd.data;
				bv_d   = 1'b1;
				hdr_d  = 1'b1;
			end
			CMD_FORB: begin
				type_d = cmd.data[6:3];
				tid_d  = 3'd0;
				sid_d  = 2'd0;
				cnt_d  = 32'd0;
				forb_d = 1'b1;
			end
			CMD_EXT: begin
				tid_d  = cmd.data[7:5];
				sid_d  = cmd.data[4:3];
				byte_d = cmd.data;
				bv_d   = 1'b1;
				hdr_d  = 1'b1;
			end
			CMD_BODY: begin
				if (cnt_q != SAT32) begin
					cnt_d = cnt_q + 32'd1;
				end
				byte_d  = cmd.data;
				bv_d    = 1'b1;
				trunc_d = cmd.trunc;
			end
			CMD_MARK: begin
				trunc_d = cmd.trunc;
			end
			default: begin
				bv_d = 1'b0;
			end
		endcase
	end

	// Per-OBU state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= 4'd0;
			tid_q   <= 3'd0;
			sid_q   <= 2'd0;
			cnt_q   <= 32'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				type_q <= type_d;
				tid_q  <= tid_d;
				sid_q  <= sid_d;
				cnt_q  <= cnt_d;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!dst_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte        <= byte_d;
			byte_valid      <= bv_d;
			is_header_byte  <= hdr_d;
			obu_end         <= cmd.last;
			obu_type        <= type_d;
			temporal_id     <= tid_d;
			spatial_id      <= sid_d;
			forbidden_error <= forb_d;
			size_truncated  <= cmd.last && trunc_d;
			body_length     <= cmd.last ? cnt_d : 32'd0;
		end
	end

	assign dst_valid = valid_q;

	a_forb_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && forbidden_error) |-> (obu_end && !byte_valid))
		else $error("forbidden error not on an end marker");

	a_len_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !obu_end) |-> (body_length == 32'd0 && !size_truncated))
		else $error("length or truncation outside OBU end");

	a_hdr_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && is_header_byte) |-> byte_valid)
		else $error("header result without byte");

endmodule
